// File: src/crcgc_pkg.sv
`default_nettype none

package crcgc_pkg;

    localparam logic [1:0]  MODE_NONE   = 2'd0;
    localparam logic [1:0]  MODE_CRC16  = 2'd1;
    localparam logic [1:0]  MODE_CRC32C = 2'd2;

    localparam logic [15:0] POLY16       = 16'h1021;
    localparam logic [31:0] POLY32C_REFL = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

    localparam logic [2:0]  LEN_CRC16  = 3'd2;
    localparam logic [2:0]  LEN_CRC32C = 3'd4;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_GEN16,
        JOB_GEN32,
        JOB_VERDICT
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] value;
        logic        pass;
    } job_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] expected_crc;
        logic [2:0]  expected_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
        logic       is_verdict;
        logic       check_passed;
    } out_item_t;

    // MSB-first CRC-16 over one byte; the upper half of the register is kept.
    function automatic logic [31:0] fold16(input logic [31:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc[15:0] ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ POLY16;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return {crc[31:16], c};
    endfunction

    // Reflected CRC-32C over one byte.
    function automatic logic [31:0] fold32c(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = {1'b0, c[31:1]} ^ POLY32C_REFL;
            end
            else
            begin
                c = {1'b0, c[31:1]};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/crcgc_front.sv
`default_nettype none

module crcgc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_data,
    input  wire logic               push,
    input  wire crcgc_pkg::in_item_t in_item,
    input  wire logic               job_full,
    output logic                    job_push,
    output crcgc_pkg::job_t         job
);
    import crcgc_pkg::*;

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_fold;
    logic        accept;
    logic        pass;

    assign accept = push && !job_full;

    always_comb
    begin
        unique case (mode_reg)
            MODE_CRC16:  crc_fold = fold16(crc_reg, in_item.data_byte);
            MODE_CRC32C: crc_fold = fold32c(crc_reg, in_item.data_byte);
            default:     crc_fold = crc_reg;
        endcase
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_CRC16:
                pass = (in_item.expected_length == LEN_CRC16) &&
                       (in_item.expected_crc[15:0] == crc_fold[15:0]);
            MODE_CRC32C:
                pass = (in_item.expected_length == LEN_CRC32C) &&
                       (in_item.expected_crc == ~crc_fold);
            default:
                pass = 1'b1;
        endcase
    end

    // A finished message becomes one job for the back end; a generate
    // request with no CRC selected yields nothing at all.
    always_comb
    begin
        job.pass  = pass;
        job.value = crc_fold;
        job.kind  = JOB_VERDICT;
        job_push  = 1'b0;
        if (in_item.req_type)
        begin
            job.kind = JOB_VERDICT;
            job_push = accept && in_item.last_byte;
        end
        else
        begin
            unique case (mode_reg)
                MODE_CRC16:
                begin
                    job.kind  = JOB_GEN16;
                    job.value = {16'h0000, crc_fold[15:0]};
                    job_push  = accept && in_item.last_byte;
                end
                MODE_CRC32C:
                begin
                    job.kind  = JOB_GEN32;
                    job.value = ~crc_fold;
                    job_push  = accept && in_item.last_byte;
                end
                default:
                begin
                    job.kind = JOB_VERDICT;
                    job_push = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next = cfg_we ? cfg_data : mode_reg;
        crc_next  = crc_reg;
        if (accept)
        begin
            crc_next = in_item.last_byte ? CRC_INIT : crc_fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            crc_reg  <= CRC_INIT;
        end
        else
        begin
            mode_reg <= mode_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

`default_nettype wire

// File: src/crcgc_job_fifo.sv
`default_nettype none

module crcgc_job_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire crcgc_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output crcgc_pkg::job_t     head
);
    import crcgc_pkg::*;

    job_t                 mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The front end only finishes a message when there is room for its job.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= JOB_CNT_W'(JOB_DEPTH))
        else $error("job count beyond queue depth");

endmodule

`default_nettype wire

// File: src/crcgc_back.sv
`default_nettype none

module crcgc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_empty,
    input  wire crcgc_pkg::job_t job,
    output logic                job_pop,
    input  wire logic           pop,
    output logic                empty,
    output crcgc_pkg::out_item_t out_item
);
    import crcgc_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    out_item_t  item;
    logic       taken;
    logic       produce;

    assign taken   = pop && out_valid_reg;
    assign produce = !job_empty && (!out_valid_reg || taken);
    assign job_pop = produce && item.last_out;

    // Head job results, MSB first; one per cycle unless the output stalls.
    always_comb
    begin
        item = '0;
        unique case (job.kind)
            JOB_GEN16:
            begin
                item.out_byte = idx_reg[0] ? job.value[7:0] : job.value[15:8];
                item.last_out = idx_reg[0];
            end
            JOB_GEN32:
            begin
                unique case (idx_reg)
                    2'd0:    item.out_byte = job.value[31:24];
                    2'd1:    item.out_byte = job.value[23:16];
                    2'd2:    item.out_byte = job.value[15:8];
                    default: item.out_byte = job.value[7:0];
                endcase
                item.last_out = (idx_reg == 2'd3);
            end
            default:
            begin
                item.last_out     = 1'b1;
                item.is_verdict   = 1'b1;
                item.check_passed = job.pass;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            idx_next       = item.last_out ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    a_gen16_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!job_empty && job.kind == JOB_GEN16) |-> idx_reg < 2'd2)
        else $error("CRC-16 byte index out of range");

    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> idx_reg == 2'd0)
        else $error("byte index not restarted after a finished job");

endmodule

`default_nettype wire

// File: src/crc16_crc32c_generate_check.sv
`default_nettype none

// Channel   Direction  Transfer when        Payload
// input     in         push && !full        in_item   (in_item_t)
// result    out        pop && !empty        out_item  (out_item_t)
// config    in         cfg_we               cfg_data  (crc_mode, 2 bits)
//
// One message byte is taken every cycle while full is low; the 8-bit CRC update is
// unrolled in the front end. A finished message queues at most one job (up to four
// waiting), and the back end emits its 2 or 4 CRC bytes, or its single verdict, at
// one result per cycle while results are popped, via a one-entry output register.
// full rises only when four finished jobs are still waiting for the back end.
// Reset selects no CRC, loads the running CRC with all ones and empties both queues.

module crc16_crc32c_generate_check (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_data,
    input  wire logic                 push,
    input  wire crcgc_pkg::in_item_t  in_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      empty,
    output crcgc_pkg::out_item_t      out_item
);
    import crcgc_pkg::*;

    logic job_push;
    job_t job_in;
    logic job_full;
    logic job_empty;
    logic job_pop;
    job_t job_head;

    crcgc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .in_item  (in_item),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    crcgc_job_fifo u_job_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job_in),
        .pop      (job_pop),
        .full     (job_full),
        .empty    (job_empty),
        .head     (job_head)
    );

    crcgc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

    assign full = job_full;

endmodule

`default_nettype wire
